>>> hw/rtl/crc8fc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the CRC-8 frame checker.
`default_nettype none

package crc8fc_pkg;

    localparam int MAX_FRAME_BYTES_DEFAULT = 4096;
    localparam int MIN_FRAME_BYTES         = 6;
    localparam int CFG_DATA_W              = 13;
    localparam int CFG_INDEX_W             = 2;

    localparam logic [7:0]  CRC_POLY             = 8'h31;
    localparam logic [12:0] FRAME_LENGTH_RESET   = 13'd2057;
    localparam logic [7:0]  CRC_START_RESET      = 8'd4;
    localparam logic [7:0]  RSSI_POSITION_RESET  = 8'd7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_CRC_START     = 2'd1,
        REG_RSSI_POSITION = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic               crc_ok;
        logic [7:0]         computed_crc;
        logic [7:0]         received_crc;
        logic signed [7:0]  rssi_dbm;
        logic [31:0]        good_frames;
        logic signed [31:0] rssi_total;
    } result_t;

    typedef struct packed {
        logic advance;
        logic load_result;
    } core_status_t;

    // MSB-first CRC-8 update over one byte, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crc8fc_if.sv
// Valid/ready channel interfaces for received bytes and per-frame results.
`default_nettype none

interface crc8fc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface crc8fc_result_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic [7:0]         computed_crc;
    logic [7:0]         received_crc;
    logic signed [7:0]  rssi_dbm;
    logic [31:0]        good_frames;
    logic signed [31:0] rssi_total;

    modport source (output valid, output crc_ok, output computed_crc, output received_crc,
                    output rssi_dbm, output good_frames, output rssi_total, input ready);
    modport sink (input valid, input crc_ok, input computed_crc, input received_crc,
                  input rssi_dbm, input good_frames, input rssi_total, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/crc8fc_in_stage.sv
// Input register that holds one received byte transaction until the core consumes it.
`default_nettype none

module crc8fc_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    crc8fc_byte_if.sink             rx_bytes,
    input  wire logic               take,
    output crc8fc_pkg::in_item_t    item,
    output logic                    item_valid
);
    import crc8fc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign rx_bytes.ready = !valid_reg || take;
    assign accept         = rx_bytes.valid && rx_bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte   <= rx_bytes.data_byte;
            item_reg.frame_start <= rx_bytes.frame_start;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/crc8fc_frame_core.sv
// Frame position tracking, CRC update, RSSI latch, CRC compare and good-frame totals.
`default_nettype none

module crc8fc_frame_core #(
    parameter int MAX_FRAME_BYTES = crc8fc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [12:0]            frame_length,
    input  wire logic [7:0]             crc_start,
    input  wire logic [7:0]             rssi_position,
    input  wire logic                   item_valid,
    input  wire crc8fc_pkg::in_item_t   item,
    input  wire logic                   out_free,
    output crc8fc_pkg::core_status_t    status,
    output crc8fc_pkg::result_t         result
);
    import crc8fc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = (POS_W + 1 > 13) ? POS_W + 1 : 13;
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [7:0]       rssi_reg;
    logic [7:0]       rssi_next;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic [31:0]      sum_reg;
    logic [31:0]      sum_next;

    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] pos;
    logic [7:0]       crc_base;
    logic [7:0]       rssi_cur;
    logic             is_last;
    logic             crc_match;
    logic             advance;
    logic [31:0]      count_upd;
    logic [31:0]      sum_upd;

    always_comb
    begin
        len_ext = LEN_W'(frame_length);
        if (len_ext < LEN_W'(MIN_FRAME_BYTES))
        begin
            eff_len = LEN_W'(MIN_FRAME_BYTES);
        end
        else if (len_ext > LEN_W'(MAX_FRAME_BYTES))
        begin
            eff_len = LEN_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            eff_len = len_ext;
        end
        last_pos = POS_W'(eff_len - LEN_W'(1));
    end

    always_comb
    begin
        pos      = item.frame_start ? '0 : pos_reg;
        crc_base = (pos == '0) ? 8'h00 : crc_reg;
        rssi_cur = (pos == '0) ? 8'h00 : rssi_reg;
        if (CMP_W'(pos) == CMP_W'(rssi_position))
        begin
            rssi_cur = item.data_byte;
        end
        is_last   = (pos >= last_pos);
        crc_match = (crc_base == item.data_byte);
        count_upd = crc_match ? count_reg + 32'd1 : count_reg;
        sum_upd   = crc_match ? sum_reg + {{24{rssi_cur[7]}}, rssi_cur} : sum_reg;
        advance   = item_valid && (!is_last || out_free);
    end

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rssi_next  = rssi_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (advance)
        begin
            rssi_next = rssi_cur;
            if (is_last)
            begin
                pos_next   = '0;
                crc_next   = crc_base;
                count_next = count_upd;
                sum_next   = sum_upd;
            end
            else
            begin
                pos_next = pos + POS_W'(1);
                if (CMP_W'(pos) >= CMP_W'(crc_start))
                begin
                    crc_next = crc8_byte(crc_base, item.data_byte);
                end
                else
                begin
                    crc_next = crc_base;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= 8'h00;
            rssi_reg  <= 8'h00;
            count_reg <= 32'd0;
            sum_reg   <= 32'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rssi_reg  <= rssi_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign status.advance     = advance;
    assign status.load_result = advance && is_last;

    assign result.crc_ok       = crc_match;
    assign result.computed_crc = crc_base;
    assign result.received_crc = item.data_byte;
    assign result.rssi_dbm     = rssi_cur;
    assign result.good_frames  = count_upd;
    assign result.rssi_total   = sum_upd;

endmodule

`default_nettype wire

>>> hw/rtl/crc8fc_out_stage.sv
// Result register that holds one frame result until the downstream side takes it.
`default_nettype none

module crc8fc_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire crc8fc_pkg::result_t result,
    output logic                    free,
    crc8fc_result_if.source         results
);
    import crc8fc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign results.valid        = valid_reg;
    assign results.crc_ok       = result_reg.crc_ok;
    assign results.computed_crc = result_reg.computed_crc;
    assign results.received_crc = result_reg.received_crc;
    assign results.rssi_dbm     = result_reg.rssi_dbm;
    assign results.good_frames  = result_reg.good_frames;
    assign results.rssi_total   = result_reg.rssi_total;

endmodule

`default_nettype wire

>>> hw/rtl/crc8_frame_checker.sv
// Top level of the CRC-8 frame checker with configuration registers and channel stages.
`default_nettype none

// The checker takes one byte transaction per cycle and gives one result transaction per
// frame once its last byte has passed the input register and then the result register; it
// keeps taking bytes while a result waits, and stalls only when a new result meets a full
// result register. Its rate is set by the combinational CRC-8 update between the registers.
// Configuration writes are taken at any time but should be made with no frame in flight.
module crc8_frame_checker #(
    parameter int MAX_FRAME_BYTES = crc8fc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [crc8fc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [crc8fc_pkg::CFG_DATA_W-1:0]    cfg_data,
    crc8fc_byte_if.sink                               rx_bytes,
    crc8fc_result_if.source                           results
);
    import crc8fc_pkg::*;

    logic [12:0]  frame_length_reg;
    logic [7:0]   crc_start_reg;
    logic [7:0]   rssi_position_reg;
    in_item_t     item;
    logic         item_valid;
    logic         out_free;
    core_status_t status;
    result_t      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= FRAME_LENGTH_RESET;
            crc_start_reg     <= CRC_START_RESET;
            rssi_position_reg <= RSSI_POSITION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_LENGTH:  frame_length_reg  <= cfg_data[12:0];
                REG_CRC_START:     crc_start_reg     <= cfg_data[7:0];
                REG_RSSI_POSITION: rssi_position_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    crc8fc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_bytes   (rx_bytes),
        .take       (status.advance),
        .item       (item),
        .item_valid (item_valid)
    );

    crc8fc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_length  (frame_length_reg),
        .crc_start     (crc_start_reg),
        .rssi_position (rssi_position_reg),
        .item_valid    (item_valid),
        .item          (item),
        .out_free      (out_free),
        .status        (status),
        .result        (result)
    );

    crc8fc_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (status.load_result),
        .result  (result),
        .free    (out_free),
        .results (results)
    );

    // A frame's last byte always leaves a result for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.load_result |=> results.valid)
        else $error("Last byte consumed without a result transaction.");

    // The core never consumes a byte that the input register does not hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.advance |-> item_valid)
        else $error("Core advanced with an empty input register.");

    // Byte transactions are refused only while a byte is held and cannot move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_bytes.ready |-> (item_valid && !status.advance))
        else $error("Input refused while the input register could accept.");

    // A registered result reports a match exactly when the two CRC bytes agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.crc_ok == (results.computed_crc == results.received_crc)))
        else $error("Result CRC flag disagrees with the CRC bytes.");

endmodule

`default_nettype wire
